// ===== src/trt_pkg.sv =====
package trt_pkg;

   localparam logic [3:0] OP_REGISTER   = 4'd0;
   localparam logic [3:0] OP_UNREGISTER = 4'd1;
   localparam logic [3:0] OP_LOOKUP     = 4'd2;
   localparam logic [3:0] OP_IS_LOCAL   = 4'd3;
   localparam logic [3:0] OP_IS_RES     = 4'd4;
   localparam logic [3:0] OP_SET_STATE  = 4'd5;
   localparam logic [3:0] OP_SET_VER    = 4'd6;
   localparam logic [3:0] OP_ACCESS     = 4'd7;
   localparam logic [3:0] OP_ACQUIRE    = 4'd8;
   localparam logic [3:0] OP_RELEASE    = 4'd9;
   localparam logic [3:0] OP_VALIDATE   = 4'd10;
   localparam logic [3:0] OP_LOCK       = 4'd11;
   localparam logic [3:0] OP_UNLOCK     = 4'd12;

   localparam logic [2:0] ST_HOT      = 3'd0;
   localparam logic [2:0] ST_WARM     = 3'd1;
   localparam logic [2:0] ST_LOCKED   = 3'd2;
   localparam logic [2:0] ST_EVICTING = 3'd3;

   localparam logic REG_PROMOTE = 1'b0;
   localparam logic REG_LOCAL   = 1'b1;

   localparam int          CSR_AW        = 3;
   localparam logic [15:0] PROMOTE_RESET = 16'd10;
   localparam logic [7:0]  LOCAL_RESET   = 8'd0;
   localparam logic [9:0]  US_PER_MS     = 10'd1000;

   typedef struct packed {
      logic [15:0] promote_threshold;
      logic [7:0]  local_node;
   } cfg_type;

   typedef struct packed {
      logic [63:0] key;
      logic [2:0]  mode;
      logic [7:0]  owner;
      logic [31:0] ver;
      logic [63:0] touch_time;
      logic [31:0] touches;
   } entry_type;

   typedef struct packed {
      logic [63:0] key;
      logic [31:0] ver;
      logic [63:0] deadline;
      logic [7:0]  node;
   } lease_type;

   function automatic logic is_resident(input logic [2:0] s);
      return (s == ST_HOT) || (s == ST_WARM) || (s == ST_LOCKED);
   endfunction

endpackage

// ===== src/tensor_residency_table.sv =====
// A request is registered, then the entry memory is scanned for its key and, for
// acquire, release and validate requests, the lease memory too; then it executes.
// One request at a time: the linear key scan over the entry memory (and the lease
// memory), one entry per cycle, runs before the next request is taken.
// Reset clears the valid bits and the counters and sets the configuration registers to their reset values at once.
module tensor_residency_table
   import trt_pkg::*;
#(
   parameter int TABLE_ENTRIES = 64,
   parameter int LEASE_ENTRIES = 32
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [3:0]          req_mode,
   input  logic [63:0]         req_tensor_id,
   input  logic [2:0]          req_state_value,
   input  logic [7:0]          req_node_value,
   input  logic [31:0]         req_version_value,
   input  logic [63:0]         req_time_value,
   input  logic [31:0]         req_count_value,
   input  logic [31:0]         req_duration_ms,
   input  logic [63:0]         req_now_us,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_ok,
   output logic [2:0]          rsp_entry_state,
   output logic [7:0]          rsp_entry_node,
   output logic [31:0]         rsp_entry_version,
   output logic [63:0]         rsp_entry_last_access,
   output logic [31:0]         rsp_entry_access_count,
   output logic [31:0]         rsp_lease_version,
   output logic [63:0]         rsp_lease_expiry_us,
   output logic [7:0]          rsp_lease_owner,
   output logic [6:0]          rsp_resident_count,
   output logic [6:0]          rsp_locked_count,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [CSR_AW-1:0]   paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);

   localparam int EW = $clog2(TABLE_ENTRIES);
   localparam int LW = (LEASE_ENTRIES > 1) ? $clog2(LEASE_ENTRIES) : 1;
   localparam logic [EW-1:0] ELAST = EW'(TABLE_ENTRIES - 1);
   localparam logic [LW-1:0] LLAST = LW'(LEASE_ENTRIES - 1);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_ESCAN = 4'b0010,
      S_LSCAN = 4'b0100,
      S_EXEC  = 4'b1000
   } fsm_type;

   cfg_type cfg;

   trt_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   fsm_type state_ff, state_in;

   logic [3:0]  mode_ff;
   logic [63:0] id_ff;
   logic [2:0]  sv_ff;
   logic [7:0]  nv_ff;
   logic [31:0] vv_ff;
   logic [63:0] tv_ff;
   logic [31:0] cv_ff;
   logic [31:0] dur_ff;
   logic [63:0] now_ff;
   logic [41:0] prod_ff;

   entry_type ent_mem [TABLE_ENTRIES];
   lease_type lease_mem [LEASE_ENTRIES];
   entry_type ent_rdata_ff;
   lease_type lease_rdata_ff;

   logic [TABLE_ENTRIES-1:0] ent_vld_ff, ent_vld_in;
   logic [LEASE_ENTRIES-1:0] lease_vld_ff, lease_vld_in;

   logic [EW-1:0] eaddr_ff, eaddr_in, ecmp_idx_ff, ecmp_idx_in, eidx_ff, eidx_in;
   logic [EW-1:0] efree_idx_ff, efree_idx_in;
   logic          eissue_ff, eissue_in, ecmp_vld_ff, ecmp_vld_in;
   logic          ehit_ff, ehit_in, efree_ff, efree_in;
   entry_type     edata_ff, edata_in;

   logic [LW-1:0] laddr_ff, laddr_in, lcmp_idx_ff, lcmp_idx_in, lidx_ff, lidx_in;
   logic [LW-1:0] lfree_idx_ff, lfree_idx_in;
   logic          lissue_ff, lissue_in, lcmp_vld_ff, lcmp_vld_in;
   logic          lhit_ff, lhit_in, lfree_ff, lfree_in;
   lease_type     ldata_ff, ldata_in;

   logic [31:0] version_ff, version_in;
   logic [6:0]  res_ff, res_in, lock_ff, lock_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        out_free, commit, edone, ldone, lease_mode;

   logic        ok;
   logic        e_we, e_set, e_clr, l_we, l_set, l_clr;
   logic [EW-1:0] e_waddr;
   logic [LW-1:0] l_waddr;
   entry_type   e_wdata;
   lease_type   l_wdata;
   logic        dec_old, inc_new;
   logic [2:0]  old_s, new_s;
   logic [31:0] touches_new;
   logic [63:0] expiry;
   logic [2:0]  o_state;
   logic [7:0]  o_node, o_lowner;
   logic [31:0] o_ver, o_count, o_lver;
   logic [63:0] o_time, o_lexp;

   logic        rsp_ok_ff;
   logic [2:0]  rsp_state_ff;
   logic [7:0]  rsp_node_ff, rsp_lowner_ff;
   logic [31:0] rsp_ver_ff, rsp_count_ff, rsp_lver_ff;
   logic [63:0] rsp_time_ff, rsp_lexp_ff;

   assign req_ready = (state_ff == S_IDLE);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign commit = (state_ff == S_EXEC) && out_free;
   assign lease_mode = (mode_ff == OP_ACQUIRE) || (mode_ff == OP_RELEASE) ||
                       (mode_ff == OP_VALIDATE);

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         mode_ff <= req_mode;
         id_ff <= req_tensor_id;
         sv_ff <= req_state_value;
         nv_ff <= req_node_value;
         vv_ff <= req_version_value;
         tv_ff <= req_time_value;
         cv_ff <= req_count_value;
         dur_ff <= req_duration_ms;
         now_ff <= req_now_us;
      end
      prod_ff <= 42'(dur_ff) * 42'(US_PER_MS);
   end

   always_ff @(posedge clock) begin
      ent_rdata_ff <= ent_mem[eaddr_ff];
      if (e_we) begin
         ent_mem[e_waddr] <= e_wdata;
      end
   end

   always_ff @(posedge clock) begin
      lease_rdata_ff <= lease_mem[laddr_ff];
      if (l_we) begin
         lease_mem[l_waddr] <= l_wdata;
      end
   end

   always_comb begin
      state_in = state_ff;
      eaddr_in = eaddr_ff;
      eissue_in = eissue_ff;
      ecmp_idx_in = eaddr_ff;
      ecmp_vld_in = 1'b0;
      ehit_in = ehit_ff;
      eidx_in = eidx_ff;
      edata_in = edata_ff;
      efree_in = efree_ff;
      efree_idx_in = efree_idx_ff;
      laddr_in = laddr_ff;
      lissue_in = lissue_ff;
      lcmp_idx_in = laddr_ff;
      lcmp_vld_in = 1'b0;
      lhit_in = lhit_ff;
      lidx_in = lidx_ff;
      ldata_in = ldata_ff;
      lfree_in = lfree_ff;
      lfree_idx_in = lfree_idx_ff;
      edone = 1'b0;
      ldone = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_ESCAN;
               eaddr_in = '0;
               eissue_in = 1'b1;
               ehit_in = 1'b0;
               efree_in = 1'b0;
               lhit_in = 1'b0;
               lfree_in = 1'b0;
            end
         end
         S_ESCAN: begin
            ecmp_vld_in = eissue_ff;
            if (eissue_ff) begin
               if (eaddr_ff == ELAST) begin
                  eissue_in = 1'b0;
               end else begin
                  eaddr_in = eaddr_ff + 1'b1;
               end
            end
            if (ecmp_vld_ff) begin
               if (ent_vld_ff[ecmp_idx_ff] && ent_rdata_ff.key == id_ff) begin
                  ehit_in = 1'b1;
                  eidx_in = ecmp_idx_ff;
                  edata_in = ent_rdata_ff;
                  edone = 1'b1;
               end else begin
                  if (!ent_vld_ff[ecmp_idx_ff] && !efree_ff) begin
                     efree_in = 1'b1;
                     efree_idx_in = ecmp_idx_ff;
                  end
                  if (ecmp_idx_ff == ELAST) begin
                     edone = 1'b1;
                  end
               end
            end
            if (edone) begin
               eissue_in = 1'b0;
               ecmp_vld_in = 1'b0;
               if (lease_mode) begin
                  state_in = S_LSCAN;
                  laddr_in = '0;
                  lissue_in = 1'b1;
               end else begin
                  state_in = S_EXEC;
               end
            end
         end
         S_LSCAN: begin
            lcmp_vld_in = lissue_ff;
            if (lissue_ff) begin
               if (laddr_ff == LLAST) begin
                  lissue_in = 1'b0;
               end else begin
                  laddr_in = laddr_ff + 1'b1;
               end
            end
            if (lcmp_vld_ff) begin
               if (lease_vld_ff[lcmp_idx_ff] && lease_rdata_ff.key == id_ff) begin
                  lhit_in = 1'b1;
                  lidx_in = lcmp_idx_ff;
                  ldata_in = lease_rdata_ff;
                  ldone = 1'b1;
               end else begin
                  if (!lease_vld_ff[lcmp_idx_ff] && !lfree_ff) begin
                     lfree_in = 1'b1;
                     lfree_idx_in = lcmp_idx_ff;
                  end
                  if (lcmp_idx_ff == LLAST) begin
                     ldone = 1'b1;
                  end
               end
            end
            if (ldone) begin
               lissue_in = 1'b0;
               lcmp_vld_in = 1'b0;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      ok = 1'b0;
      e_we = 1'b0;
      e_set = 1'b0;
      e_clr = 1'b0;
      e_waddr = eidx_ff;
      e_wdata = edata_ff;
      l_we = 1'b0;
      l_set = 1'b0;
      l_clr = 1'b0;
      l_waddr = lidx_ff;
      l_wdata = ldata_ff;
      dec_old = 1'b0;
      inc_new = 1'b0;
      old_s = edata_ff.mode;
      new_s = edata_ff.mode;
      version_in = version_ff;
      touches_new = edata_ff.touches + 32'd1;
      expiry = now_ff + 64'(prod_ff);
      o_state = '0;
      o_node = '0;
      o_ver = '0;
      o_time = '0;
      o_count = '0;
      o_lver = '0;
      o_lexp = '0;
      o_lowner = '0;
      case (mode_ff)
         OP_REGISTER: begin
            if (!ehit_ff && efree_ff) begin
               e_we = 1'b1;
               e_set = 1'b1;
               e_waddr = efree_idx_ff;
               e_wdata = '{key: id_ff, mode: sv_ff, owner: nv_ff, ver: vv_ff,
                           touch_time: tv_ff, touches: cv_ff};
               inc_new = 1'b1;
               new_s = sv_ff;
               ok = 1'b1;
            end
         end
         OP_UNREGISTER: begin
            if (ehit_ff && edata_ff.mode != ST_LOCKED) begin
               e_clr = 1'b1;
               dec_old = 1'b1;
               ok = 1'b1;
            end
         end
         OP_LOOKUP: begin
            if (ehit_ff) begin
               o_state = edata_ff.mode;
               o_node = edata_ff.owner;
               o_ver = edata_ff.ver;
               o_time = edata_ff.touch_time;
               o_count = edata_ff.touches;
               ok = 1'b1;
            end
         end
         OP_IS_LOCAL: begin
            ok = ehit_ff && (edata_ff.owner == cfg.local_node);
         end
         OP_IS_RES: begin
            ok = ehit_ff && is_resident(edata_ff.mode);
         end
         OP_SET_STATE: begin
            if (ehit_ff && !(edata_ff.mode == ST_LOCKED && sv_ff != ST_EVICTING) &&
                !(sv_ff == ST_LOCKED && edata_ff.mode == ST_EVICTING)) begin
               e_we = 1'b1;
               e_wdata.mode = sv_ff;
               e_wdata.ver = version_ff;
               dec_old = 1'b1;
               inc_new = 1'b1;
               new_s = sv_ff;
               version_in = version_ff + 32'd1;
               ok = 1'b1;
            end
         end
         OP_SET_VER: begin
            if (ehit_ff) begin
               e_we = 1'b1;
               e_wdata.ver = vv_ff;
               ok = 1'b1;
            end
         end
         OP_ACCESS: begin
            if (ehit_ff) begin
               e_we = 1'b1;
               e_wdata.touch_time = tv_ff;
               e_wdata.touches = touches_new;
               if (touches_new > 32'(cfg.promote_threshold) &&
                   edata_ff.mode == ST_WARM) begin
                  e_wdata.mode = ST_HOT;
                  dec_old = 1'b1;
                  inc_new = 1'b1;
                  new_s = ST_HOT;
               end
               ok = 1'b1;
            end
         end
         OP_ACQUIRE: begin
            if (ehit_ff && !(lhit_ff && now_ff < ldata_ff.deadline) &&
                (lhit_ff || lfree_ff)) begin
               l_we = 1'b1;
               l_set = 1'b1;
               l_waddr = lhit_ff ? lidx_ff : lfree_idx_ff;
               l_wdata = '{key: id_ff, ver: edata_ff.ver, deadline: expiry,
                           node: edata_ff.owner};
               o_lver = edata_ff.ver;
               o_lexp = expiry;
               o_lowner = edata_ff.owner;
               ok = 1'b1;
            end
         end
         OP_RELEASE: begin
            if (lhit_ff && ldata_ff.ver == vv_ff) begin
               l_clr = 1'b1;
               ok = 1'b1;
            end
         end
         OP_VALIDATE: begin
            ok = lhit_ff && (now_ff < ldata_ff.deadline) && (ldata_ff.ver == vv_ff);
         end
         OP_LOCK: begin
            if (ehit_ff && edata_ff.mode != ST_EVICTING) begin
               e_we = 1'b1;
               e_wdata.mode = ST_LOCKED;
               dec_old = 1'b1;
               inc_new = 1'b1;
               new_s = ST_LOCKED;
               ok = 1'b1;
            end
         end
         OP_UNLOCK: begin
            if (ehit_ff && edata_ff.mode == ST_LOCKED) begin
               e_we = 1'b1;
               e_wdata.mode = ST_HOT;
               dec_old = 1'b1;
               inc_new = 1'b1;
               new_s = ST_HOT;
               ok = 1'b1;
            end
         end
         default: begin
            ok = 1'b0;
         end
      endcase
      if (!commit) begin
         e_we = 1'b0;
         e_set = 1'b0;
         e_clr = 1'b0;
         l_we = 1'b0;
         l_set = 1'b0;
         l_clr = 1'b0;
         version_in = version_ff;
      end
      res_in = res_ff + 7'(inc_new && is_resident(new_s)) -
               7'(dec_old && is_resident(old_s));
      lock_in = lock_ff + 7'(inc_new && new_s == ST_LOCKED) -
                7'(dec_old && old_s == ST_LOCKED);
      ent_vld_in = ent_vld_ff;
      if (e_set) begin
         ent_vld_in[e_waddr] = 1'b1;
      end
      if (e_clr) begin
         ent_vld_in[e_waddr] = 1'b0;
      end
      lease_vld_in = lease_vld_ff;
      if (l_set) begin
         lease_vld_in[l_waddr] = 1'b1;
      end
      if (l_clr) begin
         lease_vld_in[l_waddr] = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         eissue_ff <= 1'b0;
         ecmp_vld_ff <= 1'b0;
         ehit_ff <= 1'b0;
         efree_ff <= 1'b0;
         lissue_ff <= 1'b0;
         lcmp_vld_ff <= 1'b0;
         lhit_ff <= 1'b0;
         lfree_ff <= 1'b0;
         ent_vld_ff <= '0;
         lease_vld_ff <= '0;
         version_ff <= '0;
         res_ff <= '0;
         lock_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         eissue_ff <= eissue_in;
         ecmp_vld_ff <= ecmp_vld_in;
         ehit_ff <= ehit_in;
         efree_ff <= efree_in;
         lissue_ff <= lissue_in;
         lcmp_vld_ff <= lcmp_vld_in;
         lhit_ff <= lhit_in;
         lfree_ff <= lfree_in;
         ent_vld_ff <= ent_vld_in;
         lease_vld_ff <= lease_vld_in;
         version_ff <= version_in;
         if (commit) begin
            res_ff <= res_in;
            lock_ff <= lock_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      eaddr_ff <= eaddr_in;
      ecmp_idx_ff <= ecmp_idx_in;
      eidx_ff <= eidx_in;
      edata_ff <= edata_in;
      efree_idx_ff <= efree_idx_in;
      laddr_ff <= laddr_in;
      lcmp_idx_ff <= lcmp_idx_in;
      lidx_ff <= lidx_in;
      ldata_ff <= ldata_in;
      lfree_idx_ff <= lfree_idx_in;
      if (commit) begin
         rsp_ok_ff <= ok;
         rsp_state_ff <= o_state;
         rsp_node_ff <= o_node;
         rsp_ver_ff <= o_ver;
         rsp_time_ff <= o_time;
         rsp_count_ff <= o_count;
         rsp_lver_ff <= o_lver;
         rsp_lexp_ff <= o_lexp;
         rsp_lowner_ff <= o_lowner;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_ok = rsp_ok_ff;
   assign rsp_entry_state = rsp_state_ff;
   assign rsp_entry_node = rsp_node_ff;
   assign rsp_entry_version = rsp_ver_ff;
   assign rsp_entry_last_access = rsp_time_ff;
   assign rsp_entry_access_count = rsp_count_ff;
   assign rsp_lease_version = rsp_lver_ff;
   assign rsp_lease_expiry_us = rsp_lexp_ff;
   assign rsp_lease_owner = rsp_lowner_ff;
   assign rsp_resident_count = res_ff;
   assign rsp_locked_count = lock_ff;

`ifndef SYNTHESIS
   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ESCAN && ecmp_vld_ff) |-> (ecmp_idx_ff <= ELAST))
      else $error("entry scan index out of range");

   a_version_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_EXEC) |=> $stable(version_ff))
      else $error("version counter moved outside execution");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_EXEC) |=> ($stable(res_ff) && $stable(lock_ff)))
      else $error("residency counters moved outside execution");
`endif

endmodule

// ===== src/trt_csr.sv =====
module trt_csr
   import trt_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [CSR_AW-1:0]   paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready,
   output cfg_type             cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (psel && penable && pwrite) begin
         case (paddr[2])
            REG_PROMOTE: cfg_in.promote_threshold = pwdata[15:0];
            REG_LOCAL:   cfg_in.local_node = pwdata[7:0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.promote_threshold <= PROMOTE_RESET;
         cfg_ff.local_node <= LOCAL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (paddr[2])
         REG_PROMOTE: prdata = {16'd0, cfg_ff.promote_threshold};
         REG_LOCAL:   prdata = {24'd0, cfg_ff.local_node};
         default:     prdata = 32'd0;
      endcase
   end

   assign pready = 1'b1;
   assign cfg = cfg_ff;

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top
   import trt_pkg::*;
();

   localparam int N_ENT = 64;
   localparam int N_LEASE = 32;
   localparam int IDLE_LIMIT = 20000;

   typedef struct {
      logic [3:0]  mode;
      logic [63:0] id;
      logic [2:0]  sv;
      logic [7:0]  nv;
      logic [31:0] vv;
      logic [63:0] tv;
      logic [31:0] cv;
      logic [31:0] dur;
      logic [63:0] now;
   } request_type;

   typedef struct {
      logic        ok;
      logic [2:0]  st;
      logic [7:0]  node;
      logic [31:0] ver;
      logic [63:0] last;
      logic [31:0] cnt;
      logic [31:0] lver;
      logic [63:0] lexp;
      logic [7:0]  lown;
      logic [6:0]  res;
      logic [6:0]  lck;
   } answer_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic [3:0] req_mode = 0;
   logic [63:0] req_tensor_id = 0;
   logic [2:0] req_state_value = 0;
   logic [7:0] req_node_value = 0;
   logic [31:0] req_version_value = 0;
   logic [63:0] req_time_value = 0;
   logic [31:0] req_count_value = 0;
   logic [31:0] req_duration_ms = 0;
   logic [63:0] req_now_us = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic rsp_ok;
   logic [2:0] rsp_entry_state;
   logic [7:0] rsp_entry_node;
   logic [31:0] rsp_entry_version;
   logic [63:0] rsp_entry_last_access;
   logic [31:0] rsp_entry_access_count;
   logic [31:0] rsp_lease_version;
   logic [63:0] rsp_lease_expiry_us;
   logic [7:0] rsp_lease_owner;
   logic [6:0] rsp_resident_count;
   logic [6:0] rsp_locked_count;
   logic psel = 0;
   logic penable = 0;
   logic pwrite = 0;
   logic [CSR_AW-1:0] paddr = 0;
   logic [31:0] pwdata = 0;
   logic [31:0] prdata;
   logic pready;

   tensor_residency_table DUT (.*);

   initial forever #5 clock = ~clock;

   // Shadow of the table.
   logic        t_valid [N_ENT];
   logic [63:0] t_key   [N_ENT];
   logic [2:0]  t_state [N_ENT];
   logic [7:0]  t_node  [N_ENT];
   logic [31:0] t_ver   [N_ENT];
   logic [63:0] t_time  [N_ENT];
   logic [31:0] t_cnt   [N_ENT];
   logic        l_valid [N_LEASE];
   logic [63:0] l_key   [N_LEASE];
   logic [31:0] l_ver   [N_LEASE];
   logic [63:0] l_exp   [N_LEASE];
   logic [7:0]  l_node  [N_LEASE];
   logic [31:0] stamp;
   logic [6:0]  res_total, lck_total;
   logic [15:0] cur_promote;
   logic [7:0]  cur_local;

   answer_type pending_answers[$];
   int errors = 0;
   int idle_cycles = 0;
   bit quiet_rsp = 0;
   logic [63:0] key_pool[$];

   function automatic bit resident_code(logic [2:0] s);
      return s == ST_HOT || s == ST_WARM || s == ST_LOCKED;
   endfunction

   task automatic tally(logic [2:0] s, bit add);
      if (resident_code(s)) res_total = add ? res_total + 7'd1 : res_total - 7'd1;
      if (s == ST_LOCKED) lck_total = add ? lck_total + 7'd1 : lck_total - 7'd1;
   endtask

   task automatic move_state(int i, logic [2:0] s);
      tally(t_state[i], 0);
      t_state[i] = s;
      tally(s, 1);
   endtask

   task automatic predict_table(request_type r, output answer_type a);
      int e, l, i;
      e = -1;
      l = -1;
      a = '{default: '0};
      for (i = 0; i < N_ENT; i++) if (e < 0 && t_valid[i] && t_key[i] == r.id) e = i;
      for (i = 0; i < N_LEASE; i++) if (l < 0 && l_valid[i] && l_key[i] == r.id) l = i;
      case (r.mode)
         OP_REGISTER: if (e < 0) begin
            for (i = 0; i < N_ENT; i++) if (e < 0 && !t_valid[i]) e = i;
            if (e >= 0) begin
               t_valid[e] = 1;
               t_key[e] = r.id;
               t_state[e] = r.sv;
               tally(r.sv, 1);
               t_node[e] = r.nv;
               t_ver[e] = r.vv;
               t_time[e] = r.tv;
               t_cnt[e] = r.cv;
               a.ok = 1;
            end
         end
         OP_UNREGISTER: if (e >= 0 && t_state[e] != ST_LOCKED) begin
            tally(t_state[e], 0);
            t_valid[e] = 0;
            a.ok = 1;
         end
         OP_LOOKUP: if (e >= 0) begin
            a.st = t_state[e];
            a.node = t_node[e];
            a.ver = t_ver[e];
            a.last = t_time[e];
            a.cnt = t_cnt[e];
            a.ok = 1;
         end
         OP_IS_LOCAL: a.ok = e >= 0 && t_node[e] == cur_local;
         OP_IS_RES: a.ok = e >= 0 && resident_code(t_state[e]);
         OP_SET_STATE: if (e >= 0 && !(t_state[e] == ST_LOCKED && r.sv != ST_EVICTING)
                           && !(r.sv == ST_LOCKED && t_state[e] == ST_EVICTING)) begin
            move_state(e, r.sv);
            t_ver[e] = stamp;
            stamp = stamp + 32'd1;
            a.ok = 1;
         end
         OP_SET_VER: if (e >= 0) begin
            t_ver[e] = r.vv;
            a.ok = 1;
         end
         OP_ACCESS: if (e >= 0) begin
            t_time[e] = r.tv;
            t_cnt[e] = t_cnt[e] + 32'd1;
            if (t_cnt[e] > {16'd0, cur_promote} && t_state[e] == ST_WARM)
               move_state(e, ST_HOT);
            a.ok = 1;
         end
         OP_ACQUIRE: if (e >= 0 && !(l >= 0 && r.now < l_exp[l])) begin
            if (l < 0)
               for (i = 0; i < N_LEASE; i++) if (l < 0 && !l_valid[i]) l = i;
            if (l >= 0) begin
               l_valid[l] = 1;
               l_key[l] = r.id;
               l_ver[l] = t_ver[e];
               l_exp[l] = r.now + 64'(r.dur) * 64'd1000;
               l_node[l] = t_node[e];
               a.lver = l_ver[l];
               a.lexp = l_exp[l];
               a.lown = l_node[l];
               a.ok = 1;
            end
         end
         OP_RELEASE: if (l >= 0 && l_ver[l] == r.vv) begin
            l_valid[l] = 0;
            a.ok = 1;
         end
         OP_VALIDATE: a.ok = l >= 0 && r.now < l_exp[l] && l_ver[l] == r.vv;
         OP_LOCK: if (e >= 0 && t_state[e] != ST_EVICTING) begin
            move_state(e, ST_LOCKED);
            a.ok = 1;
         end
         OP_UNLOCK: if (e >= 0 && t_state[e] == ST_LOCKED) begin
            move_state(e, ST_HOT);
            a.ok = 1;
         end
         default: ;
      endcase
      a.res = res_total;
      a.lck = lck_total;
   endtask

   task automatic send_request(request_type r);
      answer_type a;
      while ($urandom_range(99) < 28 && !quiet_rsp) begin
         req_valid <= 0;
         @(posedge clock);
      end
      predict_table(r, a);
      pending_answers.push_back(a);
      req_valid <= 1;
      req_mode <= r.mode;
      req_tensor_id <= r.id;
      req_state_value <= r.sv;
      req_node_value <= r.nv;
      req_version_value <= r.vv;
      req_time_value <= r.tv;
      req_count_value <= r.cv;
      req_duration_ms <= r.dur;
      req_now_us <= r.now;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain;
      req_valid <= 0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_AW-1:0] addr, logic [31:0] data);
      psel <= 1;
      pwrite <= 1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1;
      do @(posedge clock); while (!pready);
      psel <= 0;
      penable <= 0;
      pwrite <= 0;
      if (addr[2] == REG_PROMOTE) cur_promote = data[15:0];
      else cur_local = data[7:0];
      @(posedge clock);
   endtask

   task automatic set_config(logic [15:0] promote, logic [7:0] node);
      drain();
      write_csr(3'(REG_PROMOTE) << 2, {16'd0, promote});
      write_csr(3'(REG_LOCAL) << 2, {24'd0, node});
   endtask

   function automatic request_type blank_request(logic [3:0] mode, logic [63:0] id);
      request_type r;
      r = '{default: '0};
      r.mode = mode;
      r.id = id;
      return r;
   endfunction

   function automatic request_type random_request(logic [63:0] id);
      request_type r;
      r.mode = 4'($urandom_range(12));
      if ($urandom_range(99) < 3) r.mode = 4'($urandom_range(15, 13));
      r.id = id;
      r.sv = 3'($urandom);
      r.nv = ($urandom_range(3) == 0) ? cur_local : 8'($urandom);
      r.vv = ($urandom_range(1) == 0) ? 32'($urandom_range(3)) : $urandom;
      r.tv = {$urandom, $urandom};
      r.cv = ($urandom_range(1) == 0) ? 32'($urandom_range(20)) : $urandom;
      r.dur = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(50));
      r.now = ($urandom_range(7) == 0) ? {$urandom, $urandom} : 64'($urandom_range(200000));
      return r;
   endfunction

   function automatic logic [63:0] pick_key();
      if (key_pool.size() == 0 || $urandom_range(9) == 0) return {$urandom, $urandom};
      return key_pool[$urandom_range(key_pool.size() - 1)];
   endfunction

   task automatic test_directed;
      request_type r;
      r = blank_request(OP_REGISTER, 64'hFFFF_FFFF_FFFF_FFFF);
      r.sv = ST_WARM;
      r.nv = 8'hFF;
      r.vv = 32'hFFFF_FFFF;
      r.tv = 64'hFFFF_FFFF_FFFF_FFFF;
      r.cv = 32'hFFFF_FFFF;
      send_request(r);
      send_request(r);
      send_request(blank_request(OP_LOOKUP, r.id));
      send_request(blank_request(OP_IS_LOCAL, r.id));
      send_request(blank_request(OP_IS_RES, r.id));
      r.mode = OP_ACCESS;
      r.tv = 0;
      send_request(r);
      send_request(blank_request(OP_LOOKUP, r.id));
      r = blank_request(OP_REGISTER, 64'd0);
      r.sv = ST_EVICTING;
      send_request(r);
      r = blank_request(OP_SET_STATE, 64'd0);
      r.sv = ST_LOCKED;
      send_request(r);
      send_request(blank_request(OP_LOCK, 64'd0));
      r.sv = ST_WARM;
      send_request(r);
      send_request(blank_request(OP_LOCK, 64'hFFFF_FFFF_FFFF_FFFF));
      send_request(blank_request(OP_LOCK, 64'hFFFF_FFFF_FFFF_FFFF));
      send_request(blank_request(OP_UNREGISTER, 64'hFFFF_FFFF_FFFF_FFFF));
      r = blank_request(OP_ACQUIRE, 64'hFFFF_FFFF_FFFF_FFFF);
      r.dur = 32'hFFFF_FFFF;
      r.now = 64'hFFFF_FFFF_FFFF_FFF0;
      send_request(r);
      send_request(r);
      r.mode = OP_VALIDATE;
      r.vv = 32'hFFFF_FFFF;
      send_request(r);
      r.mode = OP_RELEASE;
      send_request(r);
      send_request(blank_request(OP_UNLOCK, 64'hFFFF_FFFF_FFFF_FFFF));
      send_request(blank_request(OP_SET_VER, 64'd0));
      send_request(blank_request(4'd15, 64'd0));
      send_request(blank_request(OP_UNREGISTER, 64'd0));
      send_request(blank_request(OP_UNREGISTER, 64'hFFFF_FFFF_FFFF_FFFF));
   endtask

   task automatic test_full_tables;
      request_type r;
      for (int i = 0; i < N_ENT + 2; i++) begin
         r = blank_request(OP_REGISTER, 64'(i + 100));
         r.sv = 3'(i);
         send_request(r);
      end
      for (int i = 0; i < N_LEASE + 2; i++) begin
         r = blank_request(OP_ACQUIRE, 64'(i + 100));
         r.dur = 1;
         send_request(r);
      end
      r = blank_request(OP_ACQUIRE, 64'd101);
      r.now = 64'd5000;
      send_request(r);
      for (int i = 0; i < N_ENT; i++) begin
         send_request(blank_request(OP_UNLOCK, 64'(i + 100)));
         send_request(blank_request(OP_UNREGISTER, 64'(i + 100)));
      end
      for (int i = 0; i < N_LEASE; i++) begin
         r = blank_request(OP_VALIDATE, 64'(i + 100));
         send_request(r);
         r.mode = OP_RELEASE;
         send_request(r);
      end
   endtask

   task automatic test_random(int count);
      request_type r;
      logic [63:0] k;
      for (int n = 0; n < count; n++) begin
         k = pick_key();
         r = random_request(k);
         if ($urandom_range(4) == 0) r.mode = OP_REGISTER;
         if (r.mode == OP_REGISTER && key_pool.size() < 40) key_pool.push_back(k);
         send_request(r);
      end
   endtask

   initial begin
      for (int i = 0; i < N_ENT; i++) t_valid[i] = 0;
      for (int i = 0; i < N_LEASE; i++) l_valid[i] = 0;
      stamp = 0;
      res_total = 0;
      lck_total = 0;
      cur_promote = PROMOTE_RESET;
      cur_local = LOCAL_RESET;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_directed();
      set_config(16'd0, 8'hFF);
      test_full_tables();
      set_config(16'd3, 8'd0);
      test_random(300);
      set_config(16'hFFFF, 8'h5A);
      quiet_rsp = 1;
      test_random(120);
      quiet_rsp = 0;
      set_config(16'd10, 8'hA5);
      test_random(400);
      drain();
      if (errors == 0) $display("tensor_residency_table regression: pass");
      else $display("tensor_residency_table regression: fail");
      $finish;
   end

   always @(posedge clock) begin
      if (reset || quiet_rsp) rsp_ready <= 1;
      else rsp_ready <= $urandom_range(99) >= 28;
   end

   always @(posedge clock) begin
      answer_type a;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_answers.size() == 0) begin
            $error("result transfer with no request outstanding");
            errors++;
         end else begin
            a = pending_answers.pop_front();
            if (rsp_ok !== a.ok) begin
               $error("ok expected %0h actual %0h", a.ok, rsp_ok); errors++;
            end
            if (rsp_entry_state !== a.st) begin
               $error("entry_state expected %0h actual %0h", a.st, rsp_entry_state); errors++;
            end
            if (rsp_entry_node !== a.node) begin
               $error("entry_node expected %0h actual %0h", a.node, rsp_entry_node); errors++;
            end
            if (rsp_entry_version !== a.ver) begin
               $error("entry_version expected %0h actual %0h", a.ver, rsp_entry_version);
               errors++;
            end
            if (rsp_entry_last_access !== a.last) begin
               $error("entry_last_access expected %0h actual %0h", a.last,
                      rsp_entry_last_access);
               errors++;
            end
            if (rsp_entry_access_count !== a.cnt) begin
               $error("entry_access_count expected %0h actual %0h", a.cnt,
                      rsp_entry_access_count);
               errors++;
            end
            if (rsp_lease_version !== a.lver) begin
               $error("lease_version expected %0h actual %0h", a.lver, rsp_lease_version);
               errors++;
            end
            if (rsp_lease_expiry_us !== a.lexp) begin
               $error("lease_expiry_us expected %0h actual %0h", a.lexp, rsp_lease_expiry_us);
               errors++;
            end
            if (rsp_lease_owner !== a.lown) begin
               $error("lease_owner expected %0h actual %0h", a.lown, rsp_lease_owner);
               errors++;
            end
            if (rsp_resident_count !== a.res) begin
               $error("resident_count expected %0d actual %0d", a.res, rsp_resident_count);
               errors++;
            end
            if (rsp_locked_count !== a.lck) begin
               $error("locked_count expected %0d actual %0d", a.lck, rsp_locked_count);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset || psel)
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tensor_residency_table regression: fail");
         $finish;
      end
   end

endmodule
